/* rtl/fsdb_pkg.sv */
// Package for the fragment stencil, depth and blend back end: sizes, codes and helpers.
package fsdb_pkg;

   localparam int PIXEL_COUNT = 4096;
   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   localparam logic [1:0] MODE_FRAG  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;

   localparam logic [2:0] CSR_STENCIL_CTRL = 3'd0;
   localparam logic [2:0] CSR_STENCIL_ACT  = 3'd1;
   localparam logic [2:0] CSR_DEPTH_CTRL   = 3'd2;
   localparam logic [2:0] CSR_BLEND_CTRL   = 3'd3;
   localparam logic [2:0] CSR_CHAN_MASK    = 3'd4;

   localparam logic [2:0] CMP_NEVER  = 3'd0;
   localparam logic [2:0] CMP_ALWAYS = 3'd1;
   localparam logic [2:0] CMP_EQ     = 3'd2;
   localparam logic [2:0] CMP_NE     = 3'd3;
   localparam logic [2:0] CMP_LT     = 3'd4;
   localparam logic [2:0] CMP_LE     = 3'd5;
   localparam logic [2:0] CMP_GT     = 3'd6;

   localparam logic [2:0] SOP_KEEP    = 3'd0;
   localparam logic [2:0] SOP_ZERO    = 3'd1;
   localparam logic [2:0] SOP_REPLACE = 3'd2;
   localparam logic [2:0] SOP_INC_SAT = 3'd3;
   localparam logic [2:0] SOP_DEC_SAT = 3'd4;
   localparam logic [2:0] SOP_INVERT  = 3'd5;
   localparam logic [2:0] SOP_INC     = 3'd6;

   localparam logic [2:0] EQ_ADD  = 3'd0;
   localparam logic [2:0] EQ_SUB  = 3'd1;
   localparam logic [2:0] EQ_RSUB = 3'd2;
   localparam logic [2:0] EQ_MIN  = 3'd3;
   localparam logic [2:0] EQ_MAX  = 3'd4;

   localparam logic [3:0] BF_ZERO  = 4'd0;
   localparam logic [3:0] BF_ONE   = 4'd1;
   localparam logic [3:0] BF_SRC   = 4'd2;
   localparam logic [3:0] BF_ISRC  = 4'd3;
   localparam logic [3:0] BF_DST   = 4'd4;
   localparam logic [3:0] BF_IDST  = 4'd5;
   localparam logic [3:0] BF_SA    = 4'd6;
   localparam logic [3:0] BF_ISA   = 4'd7;
   localparam logic [3:0] BF_DA    = 4'd8;
   localparam logic [3:0] BF_IDA   = 4'd9;

   function automatic logic cmp_fn(input logic [2:0] fn, input logic [23:0] l,
                                   input logic [23:0] r);
      case (fn)
         CMP_NEVER:  cmp_fn = 1'b0;
         CMP_ALWAYS: cmp_fn = 1'b1;
         CMP_EQ:     cmp_fn = (l == r);
         CMP_NE:     cmp_fn = (l != r);
         CMP_LT:     cmp_fn = (l < r);
         CMP_LE:     cmp_fn = (l <= r);
         CMP_GT:     cmp_fn = (l > r);
         default:    cmp_fn = (l >= r);
      endcase
   endfunction

   function automatic logic [7:0] stencil_new(input logic [2:0] op, input logic [7:0] cur,
                                              input logic [7:0] ref_v);
      case (op)
         SOP_KEEP:    stencil_new = cur;
         SOP_ZERO:    stencil_new = 8'd0;
         SOP_REPLACE: stencil_new = ref_v;
         SOP_INC_SAT: stencil_new = (cur == 8'hFF) ? 8'hFF : cur + 8'd1;
         SOP_DEC_SAT: stencil_new = (cur == 8'h00) ? 8'h00 : cur - 8'd1;
         SOP_INVERT:  stencil_new = ~cur;
         SOP_INC:     stencil_new = cur + 8'd1;
         default:     stencil_new = cur - 8'd1;
      endcase
   endfunction

   function automatic logic [8:0] factor_of(input logic [3:0] f, input logic [7:0] s,
                                            input logic [7:0] d, input logic [7:0] sa,
                                            input logic [7:0] da);
      case (f)
         BF_ZERO: factor_of = 9'd0;
         BF_ONE:  factor_of = 9'd255;
         BF_SRC:  factor_of = {1'b0, s};
         BF_ISRC: factor_of = {1'b0, ~s};
         BF_DST:  factor_of = {1'b0, d};
         BF_IDST: factor_of = {1'b0, ~d};
         BF_SA:   factor_of = {1'b0, sa};
         BF_ISA:  factor_of = {1'b0, ~sa};
         BF_DA:   factor_of = {1'b0, da};
         BF_IDA:  factor_of = {1'b0, ~da};
         default: factor_of = 9'd0;
      endcase
   endfunction

endpackage

/* rtl/fsdb_ram.sv */
// Generic RAM with one write port and one registered read port.
module fsdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/fragment_stencil_depth_blend_core.sv */
// Top level of the fragment stencil, depth and blend back end.
//
// Input channel req_*: one item per handshake, mode 0 processes a fragment,
// mode 1 writes colour, depth and stencil of a pixel, mode 2 or 3 reads it.
// Result channel rsp_*: one item per input item, carrying the pixel as
// stored after the item and fragment_kept.
// Configuration channel csr_*: register index and data, always ready;
// write only while the block is idle.
// After acceptance an item passes through the store read (registered memory
// output), the stencil and depth tests with the blend products, rounding and
// write-back, then the result register. The block processes one item at a
// time: a new item is accepted only once the previous one has left write-back,
// as the read-modify-write of the three stores must finish first.
// The channel blend uses one 8x9 multiplier per term per channel, followed by
// a register; division by 255 is a reciprocal multiply with one correction.
// Reset clears control state and loads register defaults (channel mask all
// on); the stores are undefined until written. When the receiver stalls the
// result is held; one further item is accepted and waits at write-back until
// the result register frees.
module fragment_stencil_depth_blend_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_pixel_index,
   input  logic [7:0]  req_frag_red,
   input  logic [7:0]  req_frag_green,
   input  logic [7:0]  req_frag_blue,
   input  logic [7:0]  req_frag_alpha,
   input  logic [23:0] req_frag_depth,
   input  logic [7:0]  req_stencil_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_color,
   output logic [23:0] rsp_read_depth,
   output logic [7:0]  rsp_read_stencil,
   output logic        rsp_fragment_kept,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data
);
   localparam int AW = fsdb_pkg::ADDR_W;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_WRITE} state_type;

   state_type   state_ff;
   logic [27:0] sctl_ff;
   logic [8:0]  sact_ff;
   logic [4:0]  dctl_ff;
   logic [11:0] bctl_ff;
   logic [3:0]  cmask_ff;

   logic [1:0]  mode_ff;
   logic [11:0] pix_ff;
   logic [7:0]  src_ff [4];
   logic [23:0] z_ff;
   logic [7:0]  sval_ff;

   logic [31:0] col_rd;
   logic [23:0] dep_rd;
   logic [7:0]  sten_rd;

   // Stage registers after the tests
   logic        kept_ff;
   logic        cwr_ff, dwr_ff, swr_ff;
   logic [7:0]  snew_ff;
   logic [31:0] dst_ff;
   logic [16:0] pa_ff [4];
   logic [16:0] pb_ff [4];
   logic [31:0] cout_ff;

   logic        out_valid_ff;
   logic [31:0] out_col_ff;
   logic [23:0] out_dep_ff;
   logic [7:0]  out_sten_ff;
   logic        out_kept_ff;

   logic        in_range;
   logic        accept;
   logic        out_load;
   logic        ben, sten, den, cfg_ok, spass, dpass, pass;
   logic [2:0]  eq;
   logic [3:0]  fs, fd;
   logic [7:0]  refv, cm, wm, s_cur, s_op_res;
   logic [2:0]  s_op;
   logic [7:0]  dst [4];
   logic [16:0] pa_in [4];
   logic [16:0] pb_in [4];
   logic [31:0] blend_col;

   logic        ram_we;
   logic [31:0] col_wd;
   logic [23:0] dep_wd;
   logic [7:0]  sten_wd;
   logic        col_we, dep_we, sten_we;

   assign in_range  = ({8'd0, req_pixel_index} < 20'(fsdb_pkg::PIXEL_COUNT));
   assign req_ready = (state_ff == S_IDLE) && (in_range || !out_valid_ff);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   // load the result register at write-back once it is free or being emptied, or for an out-of-range item
   assign out_load  = ((state_ff == S_WRITE) && (!out_valid_ff || rsp_ready)) ||
                      (accept && !in_range);

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_color    = out_col_ff;
   assign rsp_read_depth    = out_dep_ff;
   assign rsp_read_stencil  = out_sten_ff;
   assign rsp_fragment_kept = out_kept_ff;

   fsdb_ram #(.WIDTH(32), .DEPTH(fsdb_pkg::PIXEL_COUNT)) u_color (
      .clock(clock), .wr_en(col_we), .wr_addr(pix_ff[AW-1:0]), .wr_data(col_wd),
      .rd_addr(pix_ff[AW-1:0]), .rd_data(col_rd));
   fsdb_ram #(.WIDTH(24), .DEPTH(fsdb_pkg::PIXEL_COUNT)) u_depth (
      .clock(clock), .wr_en(dep_we), .wr_addr(pix_ff[AW-1:0]), .wr_data(dep_wd),
      .rd_addr(pix_ff[AW-1:0]), .rd_data(dep_rd));
   fsdb_ram #(.WIDTH(8), .DEPTH(fsdb_pkg::PIXEL_COUNT)) u_stencil (
      .clock(clock), .wr_en(sten_we), .wr_addr(pix_ff[AW-1:0]), .wr_data(sten_wd),
      .rd_addr(pix_ff[AW-1:0]), .rd_data(sten_rd));

   // Tests and blend products on the data read from the stores
   always_comb begin
      ben    = bctl_ff[0];
      eq     = bctl_ff[3:1];
      fs     = bctl_ff[7:4];
      fd     = bctl_ff[11:8];
      sten   = sctl_ff[0];
      den    = dctl_ff[0];
      refv   = sctl_ff[11:4];
      cm     = sctl_ff[19:12];
      wm     = sctl_ff[27:20];
      cfg_ok = !(ben && (eq > fsdb_pkg::EQ_MAX || fs > fsdb_pkg::BF_IDA ||
                         fd > fsdb_pkg::BF_IDA));
      spass  = !sten || fsdb_pkg::cmp_fn(sctl_ff[3:1], {16'd0, refv & cm},
                                         {16'd0, sten_rd & cm});
      dpass  = !den || fsdb_pkg::cmp_fn(dctl_ff[3:1], z_ff, dep_rd);
      pass   = spass && dpass;
      if (!spass) begin
         s_op = sact_ff[2:0];
      end else if (!dpass) begin
         s_op = sact_ff[5:3];
      end else begin
         s_op = sact_ff[8:6];
      end
      s_cur    = sten_rd;
      s_op_res = fsdb_pkg::stencil_new(s_op, s_cur, refv);
      for (int c = 0; c < 4; c++) begin
         dst[c]   = col_rd[8*c +: 8];
         pa_in[c] = 17'({1'b0, src_ff[c]} *
                        fsdb_pkg::factor_of(fs, src_ff[c], dst[c], src_ff[3], col_rd[31:24]));
         pb_in[c] = 17'({1'b0, dst[c]} *
                        fsdb_pkg::factor_of(fd, src_ff[c], dst[c], src_ff[3], col_rd[31:24]));
      end
   end

   // Equation, clamp, rounding divide by 255 and per-channel selection (mask, blend off, min, max)
   always_comb begin
      logic [17:0] v;
      logic [7:0]  ch;
      logic [17:0] t;
      logic [35:0] q;
      logic [9:0]  qq;
      blend_col = '0;
      for (int c = 0; c < 4; c++) begin
         case (eq)
            fsdb_pkg::EQ_ADD:  v = {1'b0, pa_ff[c]} + {1'b0, pb_ff[c]};
            fsdb_pkg::EQ_SUB:  v = (pa_ff[c] > pb_ff[c]) ? {1'b0, pa_ff[c] - pb_ff[c]} : 18'd0;
            fsdb_pkg::EQ_RSUB: v = (pb_ff[c] > pa_ff[c]) ? {1'b0, pb_ff[c] - pa_ff[c]} : 18'd0;
            default:           v = 18'd0;
         endcase
         if (v > 18'd65025) begin
            v = 18'd65025;
         end
         t  = v + 18'd127;
         q  = 36'(t) * 36'd32897;
         qq = q[32:23];
         if (18'(qq) * 18'd255 > t) begin
            qq = qq - 10'd1;
         end else if (18'(qq + 10'd1) * 18'd255 <= t) begin
            qq = qq + 10'd1;
         end
         if (!cmask_ff[c]) begin
            ch = dst_ff[8*c +: 8];
         end else if (!ben) begin
            ch = src_ff[c];
         end else if (eq == fsdb_pkg::EQ_MIN) begin
            ch = (src_ff[c] < dst_ff[8*c +: 8]) ? src_ff[c] : dst_ff[8*c +: 8];
         end else if (eq == fsdb_pkg::EQ_MAX) begin
            ch = (src_ff[c] > dst_ff[8*c +: 8]) ? src_ff[c] : dst_ff[8*c +: 8];
         end else begin
            ch = qq[7:0];
         end
         blend_col[8*c +: 8] = ch;
      end
   end

   assign ram_we  = (state_ff == S_WRITE);
   assign col_we  = ram_we && cwr_ff;
   assign dep_we  = ram_we && dwr_ff;
   assign sten_we = ram_we && swr_ff;
   assign col_wd  = (mode_ff == fsdb_pkg::MODE_WRITE) ? {src_ff[3], src_ff[2], src_ff[1], src_ff[0]}
                                                      : blend_col;
   assign dep_wd  = z_ff;
   assign sten_wd = snew_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sctl_ff      <= '0;
         sact_ff      <= '0;
         dctl_ff      <= '0;
         bctl_ff      <= '0;
         cmask_ff     <= 4'hF;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               fsdb_pkg::CSR_STENCIL_CTRL: sctl_ff  <= csr_data;
               fsdb_pkg::CSR_STENCIL_ACT:  sact_ff  <= csr_data[8:0];
               fsdb_pkg::CSR_DEPTH_CTRL:   dctl_ff  <= csr_data[4:0];
               fsdb_pkg::CSR_BLEND_CTRL:   bctl_ff  <= csr_data[11:0];
               fsdb_pkg::CSR_CHAN_MASK:    cmask_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (in_range) begin
                     state_ff <= S_READ;
                  end else begin
                     // out of range: answer zero at once
                     out_valid_ff <= 1'b1;
                     out_col_ff   <= '0;
                     out_dep_ff   <= '0;
                     out_sten_ff  <= '0;
                     out_kept_ff  <= 1'b0;
                  end
               end
            end
            S_READ: state_ff <= S_CALC;
            S_CALC: state_ff <= S_WRITE;
            S_WRITE: begin
               // hold at write-back while the previous result waits
               if (out_load) begin
                  state_ff     <= S_IDLE;
                  out_valid_ff <= 1'b1;
                  out_col_ff   <= cwr_ff ? col_wd : cout_ff;
                  out_dep_ff   <= dwr_ff ? dep_wd : dep_rd;
                  out_sten_ff  <= swr_ff ? sten_wd : sten_rd;
                  out_kept_ff  <= kept_ff;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Payload registers and the stage registers after the tests
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         pix_ff    <= req_pixel_index;
         src_ff[0] <= req_frag_red;
         src_ff[1] <= req_frag_green;
         src_ff[2] <= req_frag_blue;
         src_ff[3] <= req_frag_alpha;
         z_ff      <= req_frag_depth;
         sval_ff   <= req_stencil_value;
      end
      if (state_ff == S_CALC) begin
         // read data stays valid: RAM address and contents hold until write-back
         cout_ff <= col_rd;
         dst_ff  <= col_rd;
         for (int c = 0; c < 4; c++) begin
            pa_ff[c] <= pa_in[c];
            pb_ff[c] <= pb_in[c];
         end
         if (mode_ff == fsdb_pkg::MODE_WRITE) begin
            kept_ff <= 1'b0;
            cwr_ff  <= 1'b1;
            dwr_ff  <= 1'b1;
            swr_ff  <= 1'b1;
            snew_ff <= sval_ff;
         end else if (mode_ff == fsdb_pkg::MODE_FRAG && cfg_ok) begin
            kept_ff <= pass;
            cwr_ff  <= pass;
            dwr_ff  <= pass && dctl_ff[4];
            swr_ff  <= sten;
            snew_ff <= (sten_rd & ~wm) | (s_op_res & wm);
         end else begin
            kept_ff <= 1'b0;
            cwr_ff  <= 1'b0;
            dwr_ff  <= 1'b0;
            swr_ff  <= 1'b0;
            snew_ff <= sten_rd;
         end
      end
   end
endmodule

/* verif/fsdb_checker.sv */
// Channel monitor, pixel store predictor and result comparator for the fragment back end.
module fsdb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_pixel_index,
   input  logic [7:0]  req_frag_red,
   input  logic [7:0]  req_frag_green,
   input  logic [7:0]  req_frag_blue,
   input  logic [7:0]  req_frag_alpha,
   input  logic [23:0] req_frag_depth,
   input  logic [7:0]  req_stencil_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_color,
   input  logic [23:0] rsp_read_depth,
   input  logic [7:0]  rsp_read_stencil,
   input  logic        rsp_fragment_kept,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] color;
      logic [23:0] depth;
      logic [7:0]  stencil;
      logic        kept;
   } pixel_result_type;

   logic [31:0] color_mem [fsdb_pkg::PIXEL_COUNT];
   logic [23:0] depth_mem [fsdb_pkg::PIXEL_COUNT];
   logic [7:0]  stencil_mem [fsdb_pkg::PIXEL_COUNT];

   logic [27:0] sten_ctrl;
   logic [8:0]  sten_act;
   logic [4:0]  depth_ctrl;
   logic [11:0] blend_ctrl;
   logic [3:0]  chan_mask;

   pixel_result_type pixel_results_q[$];

   function automatic bit compare(logic [2:0] fn, logic [23:0] l, logic [23:0] r);
      case (fn)
         fsdb_pkg::CMP_NEVER:  return 1'b0;
         fsdb_pkg::CMP_ALWAYS: return 1'b1;
         fsdb_pkg::CMP_EQ:     return l == r;
         fsdb_pkg::CMP_NE:     return l != r;
         fsdb_pkg::CMP_LT:     return l < r;
         fsdb_pkg::CMP_LE:     return l <= r;
         fsdb_pkg::CMP_GT:     return l > r;
         default:              return l >= r;
      endcase
   endfunction

   function automatic logic [7:0] stencil_update(logic [2:0] op, logic [7:0] cur,
                                                 logic [7:0] refv, logic [7:0] wmask);
      logic [7:0] nxt;
      case (op)
         fsdb_pkg::SOP_KEEP:    nxt = cur;
         fsdb_pkg::SOP_ZERO:    nxt = 8'd0;
         fsdb_pkg::SOP_REPLACE: nxt = refv;
         fsdb_pkg::SOP_INC_SAT: nxt = (cur == 8'hFF) ? cur : cur + 8'd1;
         fsdb_pkg::SOP_DEC_SAT: nxt = (cur == 8'h00) ? cur : cur - 8'd1;
         fsdb_pkg::SOP_INVERT:  nxt = ~cur;
         fsdb_pkg::SOP_INC:     nxt = cur + 8'd1;
         default:               nxt = cur - 8'd1;
      endcase
      return (cur & ~wmask) | (nxt & wmask);
   endfunction

   function automatic int blend_weight(logic [3:0] f, int s, int d, int sa, int da);
      case (f)
         fsdb_pkg::BF_ZERO: return 0;
         fsdb_pkg::BF_ONE:  return 255;
         fsdb_pkg::BF_SRC:  return s;
         fsdb_pkg::BF_ISRC: return 255 - s;
         fsdb_pkg::BF_DST:  return d;
         fsdb_pkg::BF_IDST: return 255 - d;
         fsdb_pkg::BF_SA:   return sa;
         fsdb_pkg::BF_ISA:  return 255 - sa;
         fsdb_pkg::BF_DA:   return da;
         fsdb_pkg::BF_IDA:  return 255 - da;
         default:           return 0;
      endcase
   endfunction

   // Shade one fragment into the stores; returns 1 when it is kept
   function automatic bit shade_fragment(logic [11:0] pix, logic [31:0] src_rgba,
                                         logic [23:0] zf);
      bit         blend_on, sten_on, depth_on, pass;
      logic [2:0] eqn;
      logic [3:0] fsrc, fdst;
      logic [7:0] refv, cmask, wmask;
      logic [31:0] old, res;
      int         s, d, a, b, v, ch;
      blend_on = blend_ctrl[0];
      eqn      = blend_ctrl[3:1];
      fsrc     = blend_ctrl[7:4];
      fdst     = blend_ctrl[11:8];
      sten_on  = sten_ctrl[0];
      depth_on = depth_ctrl[0];
      refv     = sten_ctrl[11:4];
      cmask    = sten_ctrl[19:12];
      wmask    = sten_ctrl[27:20];
      pass     = 1'b1;
      if (blend_on && (eqn > fsdb_pkg::EQ_MAX || fsrc > fsdb_pkg::BF_IDA ||
                       fdst > fsdb_pkg::BF_IDA))
         return 1'b0;
      if (sten_on && !compare(sten_ctrl[3:1], refv & cmask, stencil_mem[pix] & cmask)) begin
         stencil_mem[pix] = stencil_update(sten_act[2:0], stencil_mem[pix], refv, wmask);
         pass = 1'b0;
      end else if (depth_on && !compare(depth_ctrl[3:1], zf, depth_mem[pix])) begin
         if (sten_on)
            stencil_mem[pix] = stencil_update(sten_act[5:3], stencil_mem[pix], refv, wmask);
         pass = 1'b0;
      end
      if (!pass)
         return 1'b0;
      if (sten_on)
         stencil_mem[pix] = stencil_update(sten_act[8:6], stencil_mem[pix], refv, wmask);
      old = color_mem[pix];
      for (int c = 0; c < 4; c++) begin
         s = src_rgba[8*c +: 8];
         d = old[8*c +: 8];
         if (!chan_mask[c])
            ch = d;
         else if (!blend_on)
            ch = s;
         else if (eqn == fsdb_pkg::EQ_MIN)
            ch = (s < d) ? s : d;
         else if (eqn == fsdb_pkg::EQ_MAX)
            ch = (s > d) ? s : d;
         else begin
            a = s * blend_weight(fsrc, s, d, src_rgba[31:24], old[31:24]);
            b = d * blend_weight(fdst, s, d, src_rgba[31:24], old[31:24]);
            v = (eqn == fsdb_pkg::EQ_ADD) ? a + b :
                ((eqn == fsdb_pkg::EQ_SUB) ? a - b : b - a);
            if (v < 0) v = 0;
            if (v > 65025) v = 65025;
            ch = (v + 127) / 255;
         end
         res[8*c +: 8] = ch[7:0];
      end
      color_mem[pix] = res;
      if (depth_ctrl[4])
         depth_mem[pix] = zf;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      pixel_result_type exp_r;
      logic [31:0]      rgba;
      if (reset) begin
         sten_ctrl  <= '0;
         sten_act   <= '0;
         depth_ctrl <= '0;
         blend_ctrl <= '0;
         chan_mask  <= 4'hF;
         pixel_results_q.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fsdb_pkg::CSR_STENCIL_CTRL: sten_ctrl  <= csr_data;
               fsdb_pkg::CSR_STENCIL_ACT:  sten_act   <= csr_data[8:0];
               fsdb_pkg::CSR_DEPTH_CTRL:   depth_ctrl <= csr_data[4:0];
               fsdb_pkg::CSR_BLEND_CTRL:   blend_ctrl <= csr_data[11:0];
               fsdb_pkg::CSR_CHAN_MASK:    chan_mask  <= csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_results_q.size() == 0) begin
               $display("%0t: result item with nothing expected: color %h depth %h sten %h kept %b",
                        $time, rsp_read_color, rsp_read_depth, rsp_read_stencil,
                        rsp_fragment_kept);
               errors <= errors + 1;
            end else begin
               exp_r = pixel_results_q.pop_front();
               if (exp_r.color !== rsp_read_color || exp_r.depth !== rsp_read_depth ||
                   exp_r.stencil !== rsp_read_stencil || exp_r.kept !== rsp_fragment_kept) begin
                  $display("%0t: mismatch: expected color %h depth %h sten %h kept %b",
                           $time, exp_r.color, exp_r.depth, exp_r.stencil, exp_r.kept);
                  $display("%0t:           actual   color %h depth %h sten %h kept %b",
                           $time, rsp_read_color, rsp_read_depth, rsp_read_stencil,
                           rsp_fragment_kept);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            rgba = {req_frag_alpha, req_frag_blue, req_frag_green, req_frag_red};
            exp_r.kept = 1'b0;
            if (req_mode == fsdb_pkg::MODE_WRITE) begin
               color_mem[req_pixel_index]   = rgba;
               depth_mem[req_pixel_index]   = req_frag_depth;
               stencil_mem[req_pixel_index] = req_stencil_value;
            end else if (req_mode == fsdb_pkg::MODE_FRAG) begin
               exp_r.kept = shade_fragment(req_pixel_index, rgba, req_frag_depth);
            end
            exp_r.color   = color_mem[req_pixel_index];
            exp_r.depth   = depth_mem[req_pixel_index];
            exp_r.stencil = stencil_mem[req_pixel_index];
            pixel_results_q.push_back(exp_r);
         end
         pending <= pixel_results_q.size();
      end
   end

endmodule

/* verif/fragment_stencil_depth_blend_core_tb.sv */
// Stimulus and verdict for the fragment stencil, depth and blend back end.
module fragment_stencil_depth_blend_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_READ_ALT = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 216;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [11:0] req_pixel_index = '0;
   logic [7:0]  req_frag_red = '0, req_frag_green = '0, req_frag_blue = '0;
   logic [7:0]  req_frag_alpha = '0, req_stencil_value = '0;
   logic [23:0] req_frag_depth = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_color;
   logic [23:0] rsp_read_depth;
   logic [7:0]  rsp_read_stencil;
   logic        rsp_fragment_kept;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [27:0] csr_data = '0;
   int          errors, pending;
   int          cycles = 0;
   int          send_idle_pct = 10, stall_pct = 70;
   logic [11:0] written_pix[$];
   bit          is_written [fsdb_pkg::PIXEL_COUNT];

   always #6 clock = ~clock;

   fragment_stencil_depth_blend_core i_dut (.*);

   fsdb_checker i_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fragment_stencil_depth_blend_core_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Leave valid high after acceptance so back-to-back items need no second assignment
   task automatic send_item(logic [1:0] mode, logic [11:0] pix, logic [31:0] rgba,
                            logic [23:0] z, logic [7:0] sv);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_pixel_index   <= pix;
      req_frag_red      <= rgba[7:0];
      req_frag_green    <= rgba[15:8];
      req_frag_blue     <= rgba[23:16];
      req_frag_alpha    <= rgba[31:24];
      req_frag_depth    <= z;
      req_stencil_value <= sv;
      do @(posedge clock); while (!req_ready);
      if (mode == fsdb_pkg::MODE_WRITE && !is_written[pix]) begin
         is_written[pix] = 1'b1;
         written_pix.push_back(pix);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [27:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let pending update first so that the count includes the item just accepted
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_depth;
      case ($urandom_range(3))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'h800000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] blend_setting;
      if ($urandom_range(9) < 2)
         return 12'($urandom);
      return {4'($urandom_range(fsdb_pkg::BF_IDA)), 4'($urandom_range(fsdb_pkg::BF_IDA)),
              3'($urandom_range(fsdb_pkg::EQ_MAX)), 1'($urandom)};
   endfunction

   task automatic program_phase(int ph);
      if (ph == 1) begin
         write_reg(fsdb_pkg::CSR_STENCIL_CTRL, 28'hFFFFFFF);
         write_reg(fsdb_pkg::CSR_STENCIL_ACT, 28'h1FF);
         write_reg(fsdb_pkg::CSR_DEPTH_CTRL, 28'h1F);
         write_reg(fsdb_pkg::CSR_BLEND_CTRL, 28'hFFF);
         write_reg(fsdb_pkg::CSR_CHAN_MASK, 28'hF);
      end else if (ph == 2) begin
         write_reg(fsdb_pkg::CSR_STENCIL_CTRL, 28'h0);
         write_reg(fsdb_pkg::CSR_STENCIL_ACT, 28'h0);
         write_reg(fsdb_pkg::CSR_DEPTH_CTRL, 28'h0);
         write_reg(fsdb_pkg::CSR_BLEND_CTRL, 28'h0);
         write_reg(fsdb_pkg::CSR_CHAN_MASK, 28'h0);
      end else begin
         write_reg(fsdb_pkg::CSR_STENCIL_CTRL,
                   {20'($urandom), 7'($urandom), 1'($urandom_range(3) != 0)});
         write_reg(fsdb_pkg::CSR_STENCIL_ACT, 28'($urandom_range(511)));
         write_reg(fsdb_pkg::CSR_DEPTH_CTRL, 28'($urandom_range(31)));
         write_reg(fsdb_pkg::CSR_BLEND_CTRL, {16'd0, blend_setting()});
         write_reg(fsdb_pkg::CSR_CHAN_MASK, 28'($urandom_range(15)));
      end
   endtask

   task automatic random_item;
      int          sel;
      logic [11:0] pix;
      sel = $urandom_range(99);
      if (written_pix.size() == 0 || sel < 15) begin
         pix = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(63));
         send_item(fsdb_pkg::MODE_WRITE, pix, $urandom, pick_depth(), 8'($urandom));
      end else begin
         // favour the last pixel touched so that same-pixel hazards occur back to back
         pix = ($urandom_range(2) == 0) ? req_pixel_index
                                        : written_pix[$urandom_range(written_pix.size() - 1)];
         if (!is_written[pix])
            pix = written_pix[0];
         if (sel < 80)
            send_item(fsdb_pkg::MODE_FRAG, pix, $urandom, pick_depth(), 8'($urandom));
         else
            send_item($urandom_range(1) ? MODE_READ : MODE_READ_ALT, pix, $urandom,
                      24'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of every field, all modes, under reset settings
      send_item(fsdb_pkg::MODE_WRITE, 12'h000, 32'h00000000, 24'h000000, 8'h00);
      send_item(fsdb_pkg::MODE_WRITE, 12'hFFF, 32'hFFFFFFFF, 24'hFFFFFF, 8'hFF);
      send_item(fsdb_pkg::MODE_WRITE, 12'hAAA, 32'hA5A55A5A, 24'hAAAAAA, 8'hAA);
      send_item(fsdb_pkg::MODE_WRITE, 12'h555, 32'h5A5AA5A5, 24'h555555, 8'h55);
      send_item(MODE_READ, 12'h000, 32'hFFFFFFFF, 24'hFFFFFF, 8'hFF);
      send_item(MODE_READ_ALT, 12'hFFF, 32'h0, 24'h0, 8'h0);
      send_item(fsdb_pkg::MODE_FRAG, 12'h000, 32'hFFFFFFFF, 24'hFFFFFF, 8'h00);
      send_item(fsdb_pkg::MODE_FRAG, 12'h000, 32'h12345678, 24'h000001, 8'h00);
      send_item(fsdb_pkg::MODE_FRAG, 12'hFFF, 32'h00000000, 24'h000000, 8'h00);
      send_item(fsdb_pkg::MODE_FRAG, 12'hAAA, 32'h80808080, 24'hAAAAAA, 8'h00);
      send_item(MODE_READ, 12'hAAA, 32'h0, 24'h0, 8'h0);
      send_item(MODE_READ, 12'h555, 32'h0, 24'h0, 8'h0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 70;
            stall_pct     = 10;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         program_phase(ph);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            random_item();
         drain();
      end

      if (errors == 0)
         $display("fragment_stencil_depth_blend_core_tb: done, clean");
      else
         $display("fragment_stencil_depth_blend_core_tb: done, errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/fsdb_pkg.sv
rtl/fsdb_ram.sv
rtl/fragment_stencil_depth_blend_core.sv
verif/fsdb_checker.sv
verif/fragment_stencil_depth_blend_core_tb.sv
